FILE: design/idetb_pkg.sv
`default_nettype none

package idetb_pkg;

    localparam int APB_ADDR_W = 5;
    localparam int APB_DATA_W = 32;
    localparam int NOW_W      = 32;

    localparam logic [APB_ADDR_W-1:0] ADDR_DEBOUNCE_MS     = 5'h00;
    localparam logic [APB_ADDR_W-1:0] ADDR_EDGE_ENABLE     = 5'h04;
    localparam logic [APB_ADDR_W-1:0] ADDR_TOGGLE_ENABLE   = 5'h08;
    localparam logic [APB_ADDR_W-1:0] ADDR_BLINK_ENABLE    = 5'h0C;
    localparam logic [APB_ADDR_W-1:0] ADDR_BLINK_PERIOD_MS = 5'h10;

    typedef struct packed {
        logic [7:0]  debounce_ms;
        logic        edge_enable;
        logic        toggle_enable;
        logic        blink_enable;
        logic [15:0] blink_period_ms;
    } cfg_t;

    localparam cfg_t CFG_RESET = '{
        debounce_ms:     8'd0,
        edge_enable:     1'b0,
        toggle_enable:   1'b0,
        blink_enable:    1'b0,
        blink_period_ms: 16'd500
    };

endpackage

`default_nettype wire

FILE: design/idetb_if.sv
`default_nettype none

interface idetb_poll_if;
    logic                         valid;
    logic                         ready;
    logic                         pin_level;
    logic [idetb_pkg::NOW_W-1:0]  now_ms;

    modport source (output valid, output pin_level, output now_ms, input ready);
    modport sink   (input valid, input pin_level, input now_ms, output ready);
endinterface

interface idetb_level_if;
    logic valid;
    logic ready;
    logic level;

    modport source (output valid, output level, input ready);
    modport sink   (input valid, input level, output ready);
endinterface

`default_nettype wire

FILE: design/idetb_cfg.sv
`default_nettype none

module idetb_cfg (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [idetb_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [idetb_pkg::APB_DATA_W-1:0] pwdata,
    output logic [idetb_pkg::APB_DATA_W-1:0] prdata,
    output logic                             pready,
    output idetb_pkg::cfg_t                  cfg
);
    import idetb_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;
    logic wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;
    assign cfg    = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            case (paddr)
                ADDR_DEBOUNCE_MS:     cfg_next.debounce_ms     = pwdata[7:0];
                ADDR_EDGE_ENABLE:     cfg_next.edge_enable     = pwdata[0];
                ADDR_TOGGLE_ENABLE:   cfg_next.toggle_enable   = pwdata[0];
                ADDR_BLINK_ENABLE:    cfg_next.blink_enable    = pwdata[0];
                ADDR_BLINK_PERIOD_MS: cfg_next.blink_period_ms = pwdata[15:0];
                default:              cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        case (paddr)
            ADDR_DEBOUNCE_MS:     prdata = {24'd0, cfg_reg.debounce_ms};
            ADDR_EDGE_ENABLE:     prdata = {31'd0, cfg_reg.edge_enable};
            ADDR_TOGGLE_ENABLE:   prdata = {31'd0, cfg_reg.toggle_enable};
            ADDR_BLINK_ENABLE:    prdata = {31'd0, cfg_reg.blink_enable};
            ADDR_BLINK_PERIOD_MS: prdata = {16'd0, cfg_reg.blink_period_ms};
            default:              prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= CFG_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

`default_nettype wire

FILE: design/idetb_chain.sv
`default_nettype none

module idetb_chain #(
    parameter int TIME_BITS = 32
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 fire,
    input  logic                 pin_level,
    input  logic [TIME_BITS-1:0] now,
    input  idetb_pkg::cfg_t      cfg,
    output logic                 level
);
    import idetb_pkg::*;

    logic                 last_raw_reg,       last_raw_next;
    logic                 stable_level_reg,   stable_level_next;
    logic [TIME_BITS-1:0] debounce_stamp_reg, debounce_stamp_next;
    logic                 edge_previous_reg,  edge_previous_next;
    logic                 toggle_latch_reg,   toggle_latch_next;
    logic                 blink_phase_reg,    blink_phase_next;
    logic [TIME_BITS-1:0] blink_stamp_reg,    blink_stamp_next;
    logic                 chain_out_reg,      chain_out_next;

    logic                 debounce_on;
    logic                 any_on;
    logic [TIME_BITS-1:0] deb_elapsed;
    logic [TIME_BITS-1:0] blink_elapsed;
    logic                 v_deb;
    logic                 v_edge;
    logic                 v_tog;
    logic                 v_blink;

    assign debounce_on   = (cfg.debounce_ms != 8'd0);
    assign any_on        = debounce_on || cfg.edge_enable || cfg.toggle_enable
                           || cfg.blink_enable;
    assign deb_elapsed   = now - debounce_stamp_reg;
    assign blink_elapsed = now - blink_stamp_reg;

    always_comb
    begin
        last_raw_next       = last_raw_reg;
        stable_level_next   = stable_level_reg;
        debounce_stamp_next = debounce_stamp_reg;
        edge_previous_next  = edge_previous_reg;
        toggle_latch_next   = toggle_latch_reg;
        blink_phase_next    = blink_phase_reg;
        blink_stamp_next    = blink_stamp_reg;

        // debounce
        v_deb = pin_level;
        if (debounce_on)
        begin
            if (deb_elapsed > TIME_BITS'(cfg.debounce_ms))
            begin
                if (last_raw_reg == pin_level)
                begin
                    stable_level_next = pin_level;
                end
                debounce_stamp_next = now;
            end
            last_raw_next = pin_level;
            v_deb         = stable_level_next;
        end

        // rising edge
        v_edge = v_deb;
        if (cfg.edge_enable)
        begin
            v_edge             = v_deb && !edge_previous_reg;
            edge_previous_next = v_deb;
        end

        // toggle
        v_tog = v_edge;
        if (cfg.toggle_enable)
        begin
            if (v_edge)
            begin
                toggle_latch_next = !toggle_latch_reg;
            end
            v_tog = toggle_latch_next;
        end

        // blink
        v_blink = v_tog;
        if (cfg.blink_enable)
        begin
            if (v_tog)
            begin
                if (blink_elapsed > TIME_BITS'(cfg.blink_period_ms))
                begin
                    blink_phase_next = !blink_phase_reg;
                    blink_stamp_next = now;
                end
            end
            else
            begin
                blink_phase_next = 1'b0;
            end
            v_blink = blink_phase_next;
        end

        chain_out_next = any_on ? v_blink : chain_out_reg;
    end

    assign level = chain_out_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_raw_reg       <= 1'b0;
            stable_level_reg   <= 1'b0;
            debounce_stamp_reg <= '0;
            edge_previous_reg  <= 1'b0;
            toggle_latch_reg   <= 1'b0;
            blink_phase_reg    <= 1'b0;
            blink_stamp_reg    <= '0;
            chain_out_reg      <= 1'b0;
        end
        else if (fire)
        begin
            last_raw_reg       <= last_raw_next;
            stable_level_reg   <= stable_level_next;
            debounce_stamp_reg <= debounce_stamp_next;
            edge_previous_reg  <= edge_previous_next;
            toggle_latch_reg   <= toggle_latch_next;
            blink_phase_reg    <= blink_phase_next;
            blink_stamp_reg    <= blink_stamp_next;
            chain_out_reg      <= chain_out_next;
        end
    end

endmodule

`default_nettype wire

FILE: design/input_debounce_edge_toggle_blink.sv
`default_nettype none

// Pin conditioning chain: each poll beat (pin_level, now_ms) passes through the
// enabled stages debounce, rising edge, toggle and blink, and yields one level
// beat; with no stage enabled the last level repeats. Throughput is one beat per
// clock unless the result side stalls. A beat passes the input register, then
// the chain update into the output register; chain state feedback closes within
// each update, so back-to-back polls are processed without bubbles. Timestamps
// are compared modulo 2^TIME_BITS. Configuration goes through the APB port at
// byte addresses 0x00..0x10 and should only change while no beat is in flight.

module input_debounce_edge_toggle_blink #(
    parameter int TIME_BITS = 32
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [idetb_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [idetb_pkg::APB_DATA_W-1:0] pwdata,
    output logic [idetb_pkg::APB_DATA_W-1:0] prdata,
    output logic                             pready,
    idetb_poll_if.sink                       poll,
    idetb_level_if.source                    result
);
    import idetb_pkg::*;

    cfg_t                 cfg;
    logic                 in_valid_reg,  in_valid_next;
    logic                 in_pin_reg;
    logic [TIME_BITS-1:0] in_now_reg;
    logic                 out_valid_reg, out_valid_next;
    logic                 out_level_reg;
    logic                 advance;
    logic                 poll_take;
    logic                 chain_level;

    idetb_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    idetb_chain #(
        .TIME_BITS (TIME_BITS)
    ) u_chain (
        .clk       (clk),
        .rst_n     (rst_n),
        .fire      (advance),
        .pin_level (in_pin_reg),
        .now       (in_now_reg),
        .cfg       (cfg),
        .level     (chain_level)
    );

    assign advance      = in_valid_reg && (!out_valid_reg || result.ready);
    assign poll.ready   = !in_valid_reg || advance;
    assign poll_take    = poll.valid && poll.ready;
    assign result.valid = out_valid_reg;
    assign result.level = out_level_reg;

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (poll_take)
        begin
            in_valid_next = 1'b1;
        end
        else if (advance)
        begin
            in_valid_next = 1'b0;
        end

        out_valid_next = out_valid_reg;
        if (advance)
        begin
            out_valid_next = 1'b1;
        end
        else if (result.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (poll_take)
        begin
            in_pin_reg <= poll.pin_level;
            in_now_reg <= TIME_BITS'(poll.now_ms);
        end
        if (advance)
        begin
            out_level_reg <= chain_level;
        end
    end

endmodule

`default_nettype wire

FILE: design/idetb_checker.sv
`default_nettype none

module idetb_checker (
    input wire logic clk,
    input wire logic rst_n,
    input wire logic poll_valid,
    input wire logic poll_ready,
    input wire logic result_valid,
    input wire logic result_ready,
    input wire logic result_level,
    input wire logic pready
);

    // a waiting level beat holds
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=> result_valid && $stable(result_level))
    else $error("level beat changed while stalled");

    // with the output empty the poll side never stalls
    assert property (@(posedge clk) disable iff (!rst_n)
        !result_valid |-> poll_ready)
    else $error("poll stalled with empty output");

    // a new level beat follows an accepted poll beat through the input and output registers
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(result_valid) |-> $past(poll_valid && poll_ready, 2))
    else $error("level beat without matching poll beat");

    assert property (@(posedge clk) disable iff (!rst_n) pready)
    else $error("pready dropped");

endmodule

bind input_debounce_edge_toggle_blink idetb_checker u_idetb_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .poll_valid   (poll.valid),
    .poll_ready   (poll.ready),
    .result_valid (result.valid),
    .result_ready (result.ready),
    .result_level (result.level),
    .pready       (pready)
);

`default_nettype wire
